// ===== sv/mcwd_pkg.sv =====
// Package: shared types and constants for the watchdog table.
`timescale 1ns / 1ps
`default_nettype none
package mcwd_pkg;

    localparam int OP_W   = 2;
    localparam int CH_W   = 4;
    localparam int TIME_W = 32;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_KICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic              ch_ok;
        logic [CH_W-1:0]   channel;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] time_stamp;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage
`default_nettype wire

// ===== sv/mcwd_if.sv =====
// Interfaces: command and response channels of the watchdog table.
`timescale 1ns / 1ps
`default_nettype none
interface mcwd_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [mcwd_pkg::OP_W-1:0]   operation;
    logic [mcwd_pkg::CH_W-1:0]   channel;
    logic [mcwd_pkg::TIME_W-1:0] duration;
    logic [mcwd_pkg::TIME_W-1:0] time_stamp;

    modport source (output valid, output operation, output channel, output duration,
                    output time_stamp, input ready);
    modport sink (input valid, input operation, input channel, input duration,
                  input time_stamp, output ready);
endinterface

interface mcwd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        accepted;
    logic [mcwd_pkg::CH_W-1:0]   report_channel;
    logic [mcwd_pkg::TIME_W-1:0] last_kick_time;
    logic                        last;

    modport source (output valid, output kind, output accepted, output report_channel,
                    output last_kick_time, output last, input ready);
    modport sink (input valid, input kind, input accepted, input report_channel,
                  input last_kick_time, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/mcwd_front.sv =====
// Front end: accept commands, range-check the channel, queue them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module mcwd_front #(
    parameter int CHANNELS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mcwd_cmd_if.sink     cmd,
    output mcwd_pkg::head_t head,
    input  wire logic    pop
);

    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    mcwd_pkg::cmd_t q_mem [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           do_pop;
    mcwd_pkg::cmd_t classified;

    assign cmd.ready = (count_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign do_pop    = pop && (count_reg != 2'd0);

    always_comb
    begin
        classified.operation  = cmd.operation;
        classified.ch_ok      = ({3'b000, cmd.channel} < CH_LIMIT);
        classified.channel    = cmd.channel;
        classified.duration   = cmd.duration;
        classified.time_stamp = cmd.time_stamp;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != 2'd0);
        head.cmd   = q_mem[rd_ptr_reg];
    end

endmodule
`default_nettype wire

// ===== sv/mcwd_back.sv =====
// Back end: channel table, command execution, timeout scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module mcwd_back #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mcwd_pkg::head_t head,
    output logic                 pop,
    mcwd_rsp_if.source           rsp
);

    localparam int NCH      = (CHANNELS < 16) ? CHANNELS : 16;
    localparam int CW       = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int TW       = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam logic [CW-1:0] LAST_IDX = CW'(NCH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [TW-1:0]  dur_mem [NCH];
    logic [TW-1:0]  lk_mem  [NCH];

    logic [1:0]     state_reg, state_next;
    logic [NCH-1:0] active_reg, active_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [TW-1:0]  now_reg, now_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [CW-1:0]  pend_ch_reg, pend_ch_next;
    logic [TW-1:0]  pend_lk_reg, pend_lk_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_kind_reg, out_kind_next;
    logic           out_acc_reg, out_acc_next;
    logic [mcwd_pkg::CH_W-1:0]   out_ch_reg, out_ch_next;
    logic [mcwd_pkg::TIME_W-1:0] out_lk_reg, out_lk_next;
    logic           out_last_reg, out_last_next;
    logic [TW-1:0]  rd_lk_reg;
    logic [TW-1:0]  rd_dur_reg;

    mcwd_pkg::cmd_t hc;
    logic [CW-1:0]  head_idx;
    logic           out_free;
    logic           ok;
    logic           advance;
    logic           exp_hit;
    logic [TW:0]    deadline;
    logic [TW-1:0]  scan_lk;
    logic [TW-1:0]  scan_dur;
    logic           we_lk, we_dur;
    logic [TW-1:0]  wr_lk, wr_dur;

    assign hc       = head.cmd;
    assign head_idx = hc.channel[CW-1:0];
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_lk  = rd_lk_reg;
    assign scan_dur = rd_dur_reg;
    assign deadline = {1'b0, scan_lk} + {1'b0, scan_dur};
    assign exp_hit  = active_reg[idx_reg] && (deadline < {1'b0, now_reg});

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_ch_next    = pend_ch_reg;
        pend_lk_next    = pend_lk_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_acc_next    = out_acc_reg;
        out_ch_next     = out_ch_reg;
        out_lk_next     = out_lk_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        ok              = 1'b0;
        advance         = 1'b0;
        we_lk           = 1'b0;
        we_dur          = 1'b0;
        wr_lk           = hc.time_stamp[TW-1:0];
        wr_dur          = hc.duration[TW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (hc.operation)
                        mcwd_pkg::OP_START,
                        mcwd_pkg::OP_STOP:
                        begin
                            if (out_free)
                            begin
                                pop = 1'b1;
                                if (hc.operation == mcwd_pkg::OP_START)
                                begin
                                    ok = hc.ch_ok && !active_reg[head_idx];
                                    if (ok)
                                    begin
                                        active_next[head_idx] = 1'b1;
                                        we_lk  = 1'b1;
                                        we_dur = 1'b1;
                                    end
                                end
                                else
                                begin
                                    ok = hc.ch_ok && active_reg[head_idx];
                                    if (ok)
                                    begin
                                        active_next[head_idx] = 1'b0;
                                    end
                                end
                                out_valid_next = 1'b1;
                                out_kind_next  = mcwd_pkg::KIND_ANSWER;
                                out_acc_next   = ok;
                                out_ch_next    = hc.channel;
                                out_lk_next    = '0;
                                out_last_next  = 1'b1;
                            end
                        end
                        mcwd_pkg::OP_KICK:
                        begin
                            pop = 1'b1;
                            if (hc.ch_ok)
                            begin
                                if (!active_reg[head_idx])
                                begin
                                    active_next[head_idx] = 1'b1;
                                    we_dur = 1'b1;
                                    wr_dur = '0;
                                end
                                we_lk = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop             = 1'b1;
                            now_next        = hc.time_stamp[TW-1:0];
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                advance = 1'b1;
                if (exp_hit)
                begin
                    if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = mcwd_pkg::KIND_TIMEOUT;
                            out_acc_next   = 1'b0;
                            out_ch_next    = mcwd_pkg::CH_W'(pend_ch_reg);
                            out_lk_next    = mcwd_pkg::TIME_W'(pend_lk_reg);
                            out_last_next  = 1'b0;
                            pend_ch_next   = idx_reg;
                            pend_lk_next   = scan_lk;
                        end
                        else
                        begin
                            advance = 1'b0;
                        end
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_ch_next    = idx_reg;
                        pend_lk_next    = scan_lk;
                    end
                end
                if (advance)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = mcwd_pkg::KIND_TIMEOUT;
                    out_acc_next    = 1'b0;
                    out_ch_next     = mcwd_pkg::CH_W'(pend_ch_reg);
                    out_lk_next     = mcwd_pkg::TIME_W'(pend_lk_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        pend_ch_reg  <= pend_ch_next;
        pend_lk_reg  <= pend_lk_next;
        out_kind_reg <= out_kind_next;
        out_acc_reg  <= out_acc_next;
        out_ch_reg   <= out_ch_next;
        out_lk_reg   <= out_lk_next;
        out_last_reg <= out_last_next;
        rd_lk_reg    <= lk_mem[idx_next];
        rd_dur_reg   <= dur_mem[idx_next];
        if (we_lk)
        begin
            lk_mem[head_idx] <= wr_lk;
        end
        if (we_dur)
        begin
            dur_mem[head_idx] <= wr_dur;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = out_kind_reg;
    assign rsp.accepted       = out_acc_reg;
    assign rsp.report_channel = out_ch_reg;
    assign rsp.last_kick_time = out_lk_reg;
    assign rsp.last           = out_last_reg;

    a_answer_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == mcwd_pkg::KIND_ANSWER)) |-> out_last_reg)
        else $error("start/stop answer without last");

    a_answer_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ((hc.operation == mcwd_pkg::OP_START) || (hc.operation == mcwd_pkg::OP_STOP)))
        |=> (out_valid_reg && (out_kind_reg == mcwd_pkg::KIND_ANSWER)))
        else $error("start/stop transfer produced no answer");

    a_kick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (hc.operation == mcwd_pkg::OP_KICK) && !out_valid_reg) |=> !out_valid_reg)
        else $error("kick produced a result");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ((state_reg == ST_IDLE) && head.valid))
        else $error("queue popped outside idle");

    a_done_empty_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !pend_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("scan did not finish");

endmodule
`default_nettype wire

// ===== sv/multi_channel_watchdog_table.sv =====
// Top level: multi-channel watchdog table, front end plus back end.
//
//   port   dir    transfer carries
//   ----   ----   -------------------------------------------------------
//   cmd    sink   operation, channel, duration, time_stamp
//   rsp    source kind, accepted, report_channel, last_kick_time, last
//
// Start, stop and kick are each handled in the back end's idle state; a check
// scans min(CHANNELS,16) entries, one entry a cycle unless a stalled rsp holds it.
// A 2-entry command queue lets cmd accept while the back end works or rsp stalls.
// Reset clears the active bits and queue; table entries need no clearing pass.
// A stalled rsp holds the scan only when a second expired channel is found.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_watchdog_table #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mcwd_cmd_if.sink   cmd,
    mcwd_rsp_if.source rsp
);

    mcwd_pkg::head_t head;
    logic            pop;

    mcwd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .head  (head),
        .pop   (pop)
    );

    mcwd_back #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire
